// File: rtl/fsk4fs_pkg.sv
// Shared types and constants for the 4FSK frame sync detector.
// No dependencies; every other file in rtl/ imports this package.
package fsk4fs_pkg;

    localparam int DEF_WINDOW_LEN       = 8;
    localparam int DEF_SYMBOL_FRAC_BITS = 4;

    localparam int SYM_W      = 8;
    localparam int PATTERN_W  = 16;
    localparam int THRESH_W   = 18;
    localparam int DIST_W     = 18;
    localparam int TYPE_W     = 3;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 18;
    localparam int PATTERN_N  = 4;

    localparam logic [PATTERN_W-1:0] LSF_RESET    = 16'h55F7;
    localparam logic [PATTERN_W-1:0] STREAM_RESET = 16'hFF5D;
    localparam logic [PATTERN_W-1:0] PACKET_RESET = 16'h75FF;
    localparam logic [PATTERN_W-1:0] BERT_RESET   = 16'hDF55;
    localparam logic [THRESH_W-1:0]  THRESH_RESET = 18'd1024;

    localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_LSF    = 3'd0,
        REG_STREAM = 3'd1,
        REG_PACKET = 3'd2,
        REG_BERT   = 3'd3,
        REG_THRESH = 3'd4
    } cfg_reg_t;

    typedef enum logic [TYPE_W-1:0] {
        SYNC_NONE   = 3'd0,
        SYNC_LSF    = 3'd1,
        SYNC_STREAM = 3'd2,
        SYNC_PACKET = 3'd3,
        SYNC_BERT   = 3'd4
    } sync_type_t;

    // pattern[0] is LSF, then stream, packet, BERT (priority order)
    typedef struct packed {
        logic [PATTERN_N-1:0][PATTERN_W-1:0] pattern;
        logic [THRESH_W-1:0]                 threshold;
    } cfg_t;

    typedef struct packed {
        logic              hit;
        logic [DIST_W-1:0] dist_sq;
    } lane_res_t;

endpackage

// File: rtl/fsk4fs_cfg_regs.sv
// Configuration register file: four sync words and the squared threshold.
// Depends on fsk4fs_pkg.
module fsk4fs_cfg_regs (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_we,
    input  logic [fsk4fs_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [fsk4fs_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    output fsk4fs_pkg::cfg_t                   cfg
);
    import fsk4fs_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_we) begin
            unique case (cfg_reg_t'(cfg_index))
                REG_LSF:    cfg_next.pattern[0] = cfg_wdata[PATTERN_W-1:0];
                REG_STREAM: cfg_next.pattern[1] = cfg_wdata[PATTERN_W-1:0];
                REG_PACKET: cfg_next.pattern[2] = cfg_wdata[PATTERN_W-1:0];
                REG_BERT:   cfg_next.pattern[3] = cfg_wdata[PATTERN_W-1:0];
                REG_THRESH: cfg_next.threshold  = cfg_wdata[THRESH_W-1:0];
                default: ; // unused index, write dropped
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.pattern[0] <= LSF_RESET;
            cfg_reg.pattern[1] <= STREAM_RESET;
            cfg_reg.pattern[2] <= PACKET_RESET;
            cfg_reg.pattern[3] <= BERT_RESET;
            cfg_reg.threshold  <= THRESH_RESET;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// File: rtl/fsk4fs_pattern_dist.sv
// One compare lane: squared distance of the symbol window to one sync word,
// threshold compare on the full sum and saturated distance. Depends on fsk4fs_pkg.
module fsk4fs_pattern_dist #(
    parameter int WINDOW_LEN       = fsk4fs_pkg::DEF_WINDOW_LEN,
    parameter int SYMBOL_FRAC_BITS = fsk4fs_pkg::DEF_SYMBOL_FRAC_BITS
) (
    input  logic signed [fsk4fs_pkg::SYM_W-1:0]     win [WINDOW_LEN],
    input  logic        [fsk4fs_pkg::PATTERN_W-1:0] pattern,
    input  logic        [fsk4fs_pkg::THRESH_W-1:0]  threshold,
    output fsk4fs_pkg::lane_res_t                   res
);
    import fsk4fs_pkg::*;

    localparam int LVL_W  = SYMBOL_FRAC_BITS + 3;
    localparam int DIFF_W = ((SYM_W > LVL_W) ? SYM_W : LVL_W) + 1;
    localparam int MAG_W  = DIFF_W - 1;
    localparam int SQ_W   = 2 * MAG_W;
    localparam int SUM_W  = SQ_W + $clog2(WINDOW_LEN);
    localparam int CMP_W  = (SUM_W > THRESH_W) ? SUM_W : THRESH_W;
    localparam int DIBITS = PATTERN_W / 2;

    localparam logic signed [DIFF_W-1:0] LVL1 = DIFF_W'(1) << SYMBOL_FRAC_BITS;
    localparam logic signed [DIFF_W-1:0] LVL3 = (LVL1 <<< 1) + LVL1;

    logic [SQ_W-1:0]  sq [WINDOW_LEN];
    logic [SUM_W-1:0] sum;
    logic [CMP_W-1:0] sum_ext;

    for (genvar i = 0; i < WINDOW_LEN; i++) begin : g_pos
        // position i uses dibit (i mod 8), most significant dibit first
        localparam int DPOS = PATTERN_W - 2 - 2 * (i % DIBITS);
        logic        [1:0]        dibit;
        logic signed [DIFF_W-1:0] level;
        logic signed [DIFF_W-1:0] sym_ext;
        logic signed [DIFF_W-1:0] diff;
        logic        [MAG_W-1:0]  mag;

        always_comb begin
            dibit   = pattern[DPOS +: 2];
            case (dibit)
                2'b01:   level = LVL3;
                2'b00:   level = LVL1;
                2'b10:   level = -LVL1;
                default: level = -LVL3;
            endcase
            sym_ext = DIFF_W'(win[i]);
            diff    = sym_ext - level;
            mag     = diff[DIFF_W-1] ? MAG_W'(-diff) : MAG_W'(diff);
            sq[i]   = SQ_W'(mag) * SQ_W'(mag);
        end
    end

    always_comb begin
        sum = '0;
        for (int i = 0; i < WINDOW_LEN; i++) begin
            sum = sum + SUM_W'(sq[i]);
        end
    end

    assign sum_ext = CMP_W'(sum);
    assign res.hit = sum_ext < CMP_W'(threshold);
    assign res.dist_sq = (sum_ext > CMP_W'(DIST_MAX)) ? DIST_MAX : sum_ext[DIST_W-1:0];

endmodule

// File: rtl/fsk4_frame_sync_detector_core.sv
// Top level of the 4FSK frame sync detector: symbol window, four compare
// lanes, priority select and result register.
// Depends on fsk4fs_pkg, fsk4fs_cfg_regs, fsk4fs_pattern_dist.
//
//  channel  | ports             | contents
//  ---------+-------------------+-------------------------------------------
//  symbols  | s_tvalid/tready   | s_tdata[7:0] soft_symbol (Q4.4 signed)
//  results  | m_tvalid/tready   | m_tdata[17:0] distance_squared, m_tuser[2:0] sync_type
//  config   | cfg_we            | cfg_index selects register, cfg_wdata data
//
// One symbol per cycle sustained while m_tready keeps the result register draining.
// A request shifts into the window register, the lanes compare in the next cycle and
// the result register takes the answer when it advances; m_tvalid offers it from there.
// Reset (aresetn low, synchronous) zeroes the window and reloads default words.
// A stall on m_tready holds the result; s_tready drops only when both the window
// stage and the result register are occupied and m_tready is low.
module fsk4_frame_sync_detector_core #(
    parameter int WINDOW_LEN       = fsk4fs_pkg::DEF_WINDOW_LEN,
    parameter int SYMBOL_FRAC_BITS = fsk4fs_pkg::DEF_SYMBOL_FRAC_BITS
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [7:0]                          s_tdata,   // [7:0] soft_symbol
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [23:0]                         m_tdata,   // [17:0] distance_squared, zero pad
    output logic [2:0]                          m_tuser,   // [2:0] sync_type
    input  logic                                cfg_we,
    input  logic [fsk4fs_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [fsk4fs_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
    import fsk4fs_pkg::*;

    cfg_t       cfg;
    lane_res_t  lane_res [PATTERN_N];

    logic signed [SYM_W-1:0] win_reg  [WINDOW_LEN];
    logic signed [SYM_W-1:0] win_next [WINDOW_LEN];
    logic                    win_vld_reg, win_vld_next;
    logic                    out_vld_reg, out_vld_next;
    sync_type_t              type_reg, type_next;
    logic [DIST_W-1:0]       dist_reg, dist_next;

    logic       out_adv;
    logic       s_acc;
    sync_type_t sel_type;
    logic [DIST_W-1:0] sel_dist;

    fsk4fs_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    for (genvar p = 0; p < PATTERN_N; p++) begin : g_lane
        fsk4fs_pattern_dist #(
            .WINDOW_LEN       (WINDOW_LEN),
            .SYMBOL_FRAC_BITS (SYMBOL_FRAC_BITS)
        ) u_lane (
            .win       (win_reg),
            .pattern   (cfg.pattern[p]),
            .threshold (cfg.threshold),
            .res       (lane_res[p])
        );
    end

    assign out_adv  = !out_vld_reg || m_tready;
    assign s_tready = !win_vld_reg || out_adv;
    assign s_acc    = s_tvalid && s_tready;

    // window: oldest symbol at index 0, shifts only on a taken request
    always_comb begin
        win_next = win_reg;
        if (s_acc) begin
            for (int i = 0; i < WINDOW_LEN - 1; i++) begin
                win_next[i] = win_reg[i+1];
            end
            win_next[WINDOW_LEN-1] = s_tdata;
        end
        win_vld_next = s_acc || (win_vld_reg && !out_adv);
    end

    // fixed priority LSF > stream > packet > BERT; miss reports the BERT distance
    always_comb begin
        sel_type = SYNC_NONE;
        sel_dist = lane_res[3].dist_sq;
        if (lane_res[0].hit) begin
            sel_type = SYNC_LSF;
            sel_dist = lane_res[0].dist_sq;
        end else if (lane_res[1].hit) begin
            sel_type = SYNC_STREAM;
            sel_dist = lane_res[1].dist_sq;
        end else if (lane_res[2].hit) begin
            sel_type = SYNC_PACKET;
            sel_dist = lane_res[2].dist_sq;
        end else if (lane_res[3].hit) begin
            sel_type = SYNC_BERT;
        end
    end

    always_comb begin
        out_vld_next = out_vld_reg;
        type_next    = type_reg;
        dist_next    = dist_reg;
        if (out_adv) begin
            out_vld_next = win_vld_reg;
            if (win_vld_reg) begin
                type_next = sel_type;
                dist_next = sel_dist;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < WINDOW_LEN; i++) begin
                win_reg[i] <= '0;
            end
            win_vld_reg <= 1'b0;
            out_vld_reg <= 1'b0;
        end else begin
            win_reg     <= win_next;
            win_vld_reg <= win_vld_next;
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        type_reg <= type_next;
        dist_reg <= dist_next;
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = 24'(dist_reg);
    assign m_tuser  = type_reg;

    a_hit_below_thresh: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_vld_reg && type_reg != SYNC_NONE) |-> (dist_reg < cfg.threshold))
        else $error("reported sync with distance not below threshold");

    a_miss_at_thresh: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_vld_reg && type_reg == SYNC_NONE) |-> (dist_reg >= cfg.threshold))
        else $error("no sync reported although distance below threshold");

    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !out_vld_reg |-> s_tready)
        else $error("input stalled with empty result register");

    a_result_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        (win_vld_reg && out_adv) |=> out_vld_reg)
        else $error("window stage advanced without producing a result");

endmodule

// File: dv/tb.sv
// Self-checking testbench for fsk4_frame_sync_detector_core: drives soft symbols
// and register writes, predicts sync type and squared distance per symbol and
// checks every result in order.
// Depends on rtl/fsk4fs_pkg.sv and rtl/fsk4_frame_sync_detector_core.sv.
module tb;
    import fsk4fs_pkg::*;

    localparam int    LIMIT_CYCLES = 400000;
    localparam int    HOLD_CYCLES  = 300;
    localparam int    PHASE_COUNT  = 10;
    localparam int    PHASE_ITEMS  = 165;

    // Tracks the window and register copy, queues one expected result per symbol request.
    class sync_scoreboard;
        typedef struct {
            sync_type_t        kind;
            logic [DIST_W-1:0] dist_sq;
        } sync_result_t;

        localparam logic [1:0] DIBIT_P1 = 2'b00;
        localparam logic [1:0] DIBIT_P3 = 2'b01;
        localparam logic [1:0] DIBIT_M1 = 2'b10;
        localparam int         DIBITS_PER_WORD = PATTERN_W / 2;

        logic signed [SYM_W-1:0] window [DEF_WINDOW_LEN];
        logic [PATTERN_W-1:0]    words [PATTERN_N];
        logic [THRESH_W-1:0]     thresh;
        sync_type_t              lane_kind [PATTERN_N];
        sync_result_t            expected_q [$];
        int unsigned             errors;

        function new();
            for (int i = 0; i < DEF_WINDOW_LEN; i++) window[i] = '0;
            words[REG_LSF]    = LSF_RESET;
            words[REG_STREAM] = STREAM_RESET;
            words[REG_PACKET] = PACKET_RESET;
            words[REG_BERT]   = BERT_RESET;
            thresh = THRESH_RESET;
            lane_kind = '{SYNC_LSF, SYNC_STREAM, SYNC_PACKET, SYNC_BERT};
            errors = 0;
        endfunction

        // Ideal level of window position pos for a sync word; the word repeats past 8 dibits.
        static function int ideal_symbol(logic [PATTERN_W-1:0] word, int pos);
            int         mag;
            logic [1:0] dibit;
            mag   = 1 << DEF_SYMBOL_FRAC_BITS;
            dibit = word[PATTERN_W - 2 - 2 * (pos % DIBITS_PER_WORD) +: 2];
            case (dibit)
                DIBIT_P3: return 3 * mag;
                DIBIT_P1: return mag;
                DIBIT_M1: return -mag;
                default:  return -3 * mag;
            endcase
        endfunction

        function int unsigned window_distance(logic [PATTERN_W-1:0] word);
            int unsigned sum;
            int          diff;
            sum = 0;
            for (int i = 0; i < DEF_WINDOW_LEN; i++) begin
                diff = int'(window[i]) - ideal_symbol(word, i);
                sum += diff * diff;
            end
            return sum;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_LSF:    words[REG_LSF]    = data[PATTERN_W-1:0];
                REG_STREAM: words[REG_STREAM] = data[PATTERN_W-1:0];
                REG_PACKET: words[REG_PACKET] = data[PATTERN_W-1:0];
                REG_BERT:   words[REG_BERT]   = data[PATTERN_W-1:0];
                REG_THRESH: thresh            = data[THRESH_W-1:0];
                default: ;  // unmapped index, write dropped
            endcase
        endfunction

        function void note_symbol(logic [SYM_W-1:0] sym);
            sync_result_t res;
            int unsigned  sum;
            for (int i = 0; i < DEF_WINDOW_LEN - 1; i++) window[i] = window[i + 1];
            window[DEF_WINDOW_LEN - 1] = sym;
            res.kind = SYNC_NONE;
            sum = 0;
            // priority order; distance reported is the last lane evaluated
            for (int p = 0; p < PATTERN_N; p++) begin
                sum = window_distance(words[p]);
                if (sum < thresh) begin
                    res.kind = lane_kind[p];
                    break;
                end
            end
            res.dist_sq = (sum > DIST_MAX) ? DIST_MAX : sum[DIST_W-1:0];
            expected_q.push_back(res);
        endfunction

        function void check_result(logic [TYPE_W-1:0] kind, logic [23:0] data);
            sync_result_t exp_res;
            if (expected_q.size() == 0) begin
                $error("sync result with no request pending: sync_type %0d distance_squared %0d",
                       kind, data[DIST_W-1:0]);
                errors++;
            end else begin
                exp_res = expected_q.pop_front();
                if (kind !== exp_res.kind) begin
                    $error("sync_type: expected %0d, actual %0d", exp_res.kind, kind);
                    errors++;
                end
                if (data[DIST_W-1:0] !== exp_res.dist_sq) begin
                    $error("distance_squared: expected %0d, actual %0d",
                           exp_res.dist_sq, data[DIST_W-1:0]);
                    errors++;
                end
                if (data[23:DIST_W] !== '0) begin
                    $error("tdata pad: expected 0, actual %0h", data[23:DIST_W]);
                    errors++;
                end
            end
        endfunction
    endclass

    logic                  aclk = 1'b0;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [7:0]            s_tdata;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [23:0]           m_tdata;
    logic [2:0]            m_tuser;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    sync_scoreboard sb;
    bit             no_idle  = 1'b0;
    bit             hold_out = 1'b0;

    fsk4_frame_sync_detector_core u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) sb.check_result(m_tuser, m_tdata);
    end

    // result sink: random stalls, one long hold-off on request
    initial begin
        m_tready <= 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            if (hold_out) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_out = 1'b0;
            end else if (!no_idle && $urandom_range(0, 4) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 7)) @(posedge aclk);
            end else begin
                m_tready <= 1'b1;
                repeat ($urandom_range(1, 12)) @(posedge aclk);
            end
        end
    end

    initial begin
        repeat (LIMIT_CYCLES) @(posedge aclk);
        $display("tb: failure");
        $finish;
    end

    task automatic send_symbol(logic [7:0] sym);
        s_tvalid <= 1'b1;
        s_tdata  <= sym;
        do @(posedge aclk); while (!s_tready);
        sb.note_symbol(sym);
        if (!no_idle && $urandom_range(0, 5) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge aclk);
        end
    endtask

    // first len symbols of a sync word, each level jittered by up to +/- amp
    task automatic send_word(logic [PATTERN_W-1:0] word, int len, int amp);
        int v;
        for (int k = 0; k < len; k++) begin
            v = sync_scoreboard::ideal_symbol(word, k) + $urandom_range(0, 2 * amp) - amp;
            if (v > 127) v = 127;
            if (v < -128) v = -128;
            send_symbol(v[7:0]);
        end
    endtask

    task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge aclk);
        sb.write_reg(idx, data);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (sb.expected_q.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic load_config(int phase);
        logic [PATTERN_W-1:0] word;
        logic [THRESH_W-1:0]  th;
        int                   sel;
        for (int r = 0; r < PATTERN_N; r++) begin
            case ($urandom_range(0, 5))
                0: word = '0;
                1: word = '1;
                2: word = (r == REG_LSF) ? LSF_RESET : (r == REG_STREAM) ? STREAM_RESET :
                          (r == REG_PACKET) ? PACKET_RESET : BERT_RESET;
                default: word = PATTERN_W'($urandom_range(0, 16'hFFFF));
            endcase
            // upper data bits are outside the pattern register
            cfg_write(r[CFG_IDX_W-1:0], {2'($urandom_range(0, 3)), word});
        end
        sel = (phase < 5) ? phase : $urandom_range(0, 4);
        case (sel)
            0:       th = THRESH_RESET;
            1:       th = THRESH_W'($urandom_range(0, 4096));
            2:       th = '0;
            3:       th = '1;
            default: th = THRESH_W'($urandom_range(0, 18'h3FFFF));
        endcase
        cfg_write(REG_THRESH, th);
        cfg_we <= 1'b0;
    endtask

    task automatic run_random_phase(int n_items);
        int sent;
        int pick;
        int len;
        int amp;
        sent = 0;
        while (sent < n_items) begin
            pick = $urandom_range(0, 9);
            if (pick < 7) begin
                case ($urandom_range(0, 4))
                    0: amp = 0;
                    1: amp = 4;
                    2: amp = 12;
                    3: amp = 24;
                    default: amp = 48;
                endcase
                len = (pick == 6) ? $urandom_range(1, 7) : 8;  // broken word when short
                send_word(sb.words[$urandom_range(0, PATTERN_N - 1)], len, amp);
            end else begin
                len = $urandom_range(1, 6);
                repeat (len) send_symbol(8'($urandom_range(0, 255)));
            end
            sent += len;
        end
    endtask

    initial begin
        aresetn   <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        cfg_we    <= 1'b0;
        cfg_index <= REG_LSF;
        cfg_wdata <= '0;
        sb = new();
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // defaults: symbol extremes, then exact LSF and BERT words
        send_symbol(8'h80);
        send_symbol(8'h7F);
        send_symbol(8'h00);
        send_word(LSF_RESET, 8, 0);
        send_word(BERT_RESET, 8, 0);
        wait_drained();

        // zero threshold never matches
        cfg_write(REG_THRESH, '0);
        cfg_we <= 1'b0;
        send_word(STREAM_RESET, 2, 0);
        wait_drained();

        // full-scale threshold: LSF wins on anything
        cfg_write(REG_THRESH, '1);
        cfg_we <= 1'b0;
        send_symbol(8'h80);
        send_symbol(8'h7F);
        wait_drained();

        // unmapped indexes must leave every register alone
        for (int i = int'(REG_THRESH) + 1; i < (1 << CFG_IDX_W); i++)
            cfg_write(i[CFG_IDX_W-1:0], CFG_DATA_W'($urandom_range(0, 18'h3FFFF)));
        cfg_write(REG_THRESH, THRESH_RESET);
        cfg_we <= 1'b0;
        send_word(PACKET_RESET, 2, 0);
        wait_drained();

        for (int ph = 0; ph < PHASE_COUNT; ph++) begin
            load_config(ph);
            if (ph == 1) hold_out = 1'b1;
            if (ph == PHASE_COUNT - 1) no_idle = 1'b1;
            run_random_phase(PHASE_ITEMS);
            wait_drained();
        end

        repeat (8) @(posedge aclk);
        if (sb.expected_q.size() != 0) begin
            $error("%0d sync results never arrived", sb.expected_q.size());
            sb.errors++;
        end
        if (sb.errors == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end
endmodule

// File: filelist.f
rtl/fsk4fs_pkg.sv
rtl/fsk4fs_cfg_regs.sv
rtl/fsk4fs_pattern_dist.sv
rtl/fsk4_frame_sync_detector_core.sv
dv/tb.sv
